// ===== rtl/decimal_ascii_formatter_macros.svh =====
// ----------------------------------------------------------------------------
// Decimal ASCII formatter assertion macros
// Shorthand for the clocked implication checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ASCII_FORMATTER_MACROS_SVH
`define DECIMAL_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DFMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dfmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal ASCII formatter package
// Shared constants and the control and character word types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfmt_pkg;

	localparam int BIN_W = 32;
	localparam int STEP_W = $clog2(BIN_W);

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_POINT = 8'h2E;

	// Commands from the sequencer to the shared conversion unit.
	typedef struct packed {
		logic load;
		logic dabble;
		logic digit_shift;
	} bcd_cmd_t;

	// One character word leaving the sequencer.
	typedef struct packed {
		logic       valid;
		logic [7:0] ch;
		logic       last;
	} char_word_t;

endpackage

// ===== rtl/dfmt_bcd_unit.sv =====
// ----------------------------------------------------------------------------
// Decimal ASCII formatter conversion unit
// Shift-add-3 binary to BCD converter that also shifts digits out, top first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfmt_bcd_unit #(
	parameter int MAX_DIGITS = 10
) (
	input  logic              clk,
	input  dfmt_pkg::bcd_cmd_t cmd,
	input  logic [31:0]       value,
	output logic [3:0]        top_digit
);
	import dfmt_pkg::*;

	localparam int BCD_W = 4 * MAX_DIGITS;

	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	// Each digit of five or more gets three added before the doubling.
	always_comb begin
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	// Carries out of the top digit are dropped, which keeps value mod 10^MAX_DIGITS.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cmd.dabble) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end else if (cmd.digit_shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

endmodule

// ===== rtl/dfmt_seq.sv =====
// ----------------------------------------------------------------------------
// Decimal ASCII formatter sequencer
// Runs the conversion steps, then walks the digits and builds the characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfmt_seq #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [3:0]            frac_digits,
	input  logic                  pad_two,
	input  logic [3:0]            top_digit,
	output logic                  busy,
	output dfmt_pkg::bcd_cmd_t    cmd,
	output dfmt_pkg::char_word_t  word
);
	import dfmt_pkg::*;

	localparam int PW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_DOT  = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [PW-1:0]     pos_q, pos_d;
	logic [PW-1:0]     frac_q, frac_d;
	logic              pad_q, pad_d;
	logic              seen_q, seen_d;
	logic [PW-1:0]     frac_sat;
	logic              skip;

	always_comb begin
		if (32'(frac_digits) > MAX_DIGITS - 1) begin
			frac_sat = PW'(MAX_DIGITS - 1);
		end else begin
			frac_sat = PW'(frac_digits);
		end
	end

	// A leading zero above the minimum field width prints nothing.
	assign skip = !seen_q && (top_digit == 4'd0) &&
		(CW'(pos_q) >= CW'(frac_q) + CW'(pad_q) + CW'(1));

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		pos_d = pos_q;
		frac_d = frac_q;
		pad_d = pad_q;
		seen_d = seen_q;
		cmd = '0;
		word = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					frac_d = frac_sat;
					pad_d = pad_two;
					step_d = '0;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(BIN_W - 1)) begin
					pos_d = PW'(MAX_DIGITS - 1);
					seen_d = 1'b0;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.digit_shift = 1'b1;
				if (skip) begin
					pos_d = pos_q - PW'(1);
				end else begin
					word.valid = 1'b1;
					word.ch = CHAR_ZERO + 8'(top_digit);
					seen_d = 1'b1;
					if (pos_q == frac_q && frac_q != '0) begin
						state_d = ST_DOT;
					end else if (pos_q == '0) begin
						word.last = 1'b1;
						state_d = ST_IDLE;
					end else begin
						pos_d = pos_q - PW'(1);
					end
				end
			end
			ST_DOT: begin
				word.valid = 1'b1;
				word.ch = CHAR_POINT;
				pos_d = pos_q - PW'(1);
				state_d = ST_EMIT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			pos_q <= '0;
			seen_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			pos_q <= pos_d;
			seen_q <= seen_d;
		end
	end

	always_ff @(posedge clk) begin
		frac_q <= frac_d;
		pad_q <= pad_d;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/decimal_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// Decimal ASCII formatter
// Prints an unsigned 32-bit value as ASCII decimal with an implied point.
// ----------------------------------------------------------------------------
// Usage: drive value, frac_digits and pad_two and raise start; the word is
// taken at the rising edge where start is high and busy is low. busy then
// stays high until the last character has left the sequencer.
// Results come out one character per word on ascii_char with last_char
// marking the final one, each valid for the single cycle in which strobe is
// high. The receiver cannot hold results off; characters of one number come
// on consecutive cycles.
// Sequence: a load, then shift-add-3 steps in the shared BCD unit, one per
// bit of value, then the digit positions in turn from the top of the
// MAX_DIGITS-digit field (suppressed leading zeros print nothing), with a
// point word before the fraction digits when frac_digits is not zero.
// Reset (arst_n low) returns the block to idle at once and drops strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_ascii_formatter_macros.svh"

module decimal_ascii_formatter #(
	parameter int MAX_DIGITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	input  logic [3:0]  frac_digits,
	input  logic        pad_two,
	output logic        strobe,
	output logic [7:0]  ascii_char,
	output logic        last_char
);
	import dfmt_pkg::*;

	bcd_cmd_t   cmd;
	char_word_t word;
	logic [3:0] top_digit;
	logic       strobe_q;
	logic [7:0] char_q;
	logic       last_q;

	dfmt_bcd_unit #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_bcd (
		.clk       (clk),
		.cmd       (cmd),
		.value     (value),
		.top_digit (top_digit)
	);

	dfmt_seq #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.frac_digits (frac_digits),
		.pad_two     (pad_two),
		.top_digit   (top_digit),
		.busy        (busy),
		.cmd         (cmd),
		.word        (word)
	);

	// Output register for the character words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= word.valid;
		end
	end

	always_ff @(posedge clk) begin
		char_q <= word.ch;
		last_q <= word.last;
	end

	assign strobe = strobe_q;
	assign ascii_char = char_q;
	assign last_char = last_q;

	`DFMT_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy,
		"accepted word did not raise busy")
	`DFMT_ASSERT_NXT(a_chars_back_to_back, clk, arst_n, strobe && !last_char, strobe,
		"gap inside a number")
	`DFMT_ASSERT_NXT(a_last_ends, clk, arst_n, strobe && last_char, !strobe,
		"character followed the last one")
	`DFMT_ASSERT_IMP(a_char_legal, clk, arst_n, strobe,
		ascii_char == CHAR_POINT ||
		(ascii_char >= CHAR_ZERO && ascii_char <= CHAR_ZERO + 8'd9),
		"illegal character code")

endmodule

// ===== tb/sv/decimal_ascii_formatter_test.sv =====
// ----------------------------------------------------------------------------
// Decimal ASCII formatter testbench
// Feeds numbers with random point positions and pad flags to the formatter.
// It predicts each character string and checks every character word in
// order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_ascii_formatter_test;

	import dfmt_pkg::*;

	localparam int DIGITS = 10;
	localparam int RANDOM_NUMBERS = 400;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 60;

	// Holds the characters still owed by the formatter, oldest first.
	class char_stream_check;
		typedef struct {
			logic [7:0] ch;
			logic       last;
		} char_exp_t;

		char_exp_t owed_chars[$];
		int        fault_count;

		function new();
			fault_count = 0;
		endfunction

		// Works out the printed form of one accepted number.
		function void note_number(logic [31:0] num, logic [3:0] frac_in, logic pad);
			logic [3:0]      digit [DIGITS];
			longint unsigned rest;
			int              sig;
			int              frac;
			int              field;
			char_exp_t       c;

			rest = num;
			sig = 0;
			for (int i = 0; i < DIGITS; i++) begin
				digit[i] = 4'(rest % 10);
				rest = rest / 10;
				if (digit[i] != 0)
					sig = i + 1;
			end
			frac = (frac_in > DIGITS - 1) ? DIGITS - 1 : frac_in;
			field = frac + (pad ? 2 : 1);
			if (sig > field)
				field = sig;
			if (field > DIGITS)
				field = DIGITS;

			c.last = 1'b0;
			for (int i = field; i > frac; i--) begin
				c.ch = CHAR_ZERO + digit[i - 1];
				owed_chars.push_back(c);
			end
			if (frac > 0) begin
				c.ch = CHAR_POINT;
				owed_chars.push_back(c);
				for (int i = frac; i > 0; i--) begin
					c.ch = CHAR_ZERO + digit[i - 1];
					owed_chars.push_back(c);
				end
			end
			owed_chars[owed_chars.size() - 1].last = 1'b1;
		endfunction

		function void check_char(logic [7:0] ch, logic last);
			char_exp_t want;

			if (owed_chars.size() == 0) begin
				$error("unexpected character word: ascii_char=%h last_char=%b", ch, last);
				fault_count++;
				return;
			end
			want = owed_chars.pop_front();
			if (ch !== want.ch) begin
				$error("ascii_char: expected %h, got %h", want.ch, ch);
				fault_count++;
			end
			if (last !== want.last) begin
				$error("last_char: expected %b, got %b", want.last, last);
				fault_count++;
			end
		endfunction

		function int owed();
			return owed_chars.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] value;
	logic [3:0]  frac_digits;
	logic        pad_two;
	logic        strobe;
	logic [7:0]  ascii_char;
	logic        last_char;

	char_stream_check board = new();
	int               quiet_cycles = 0;

	decimal_ascii_formatter uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.frac_digits (frac_digits),
		.pad_two     (pad_two),
		.strobe      (strobe),
		.ascii_char  (ascii_char),
		.last_char   (last_char)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Checks character words and watches for a stalled run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				board.check_char(ascii_char, last_char);
			if (strobe || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Presents one number, with an optional gap before it, and waits for the
	// formatter to take it.
	task automatic send_number(logic [31:0] num, logic [3:0] frac, logic pad, bit may_idle);
		int gap;

		gap = 0;
		if (may_idle && $urandom_range(99) < 17)
			gap = $urandom_range(1, 50);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= num;
		frac_digits <= frac;
		pad_two <= pad;
		do
			@(posedge clk);
		while (busy);
		board.note_number(num, frac, pad);
	endtask

	// Spreads values over every decimal length and near powers of ten.
	function automatic logic [31:0] random_value();
		longint unsigned scale;
		int              len;

		scale = 1;
		len = $urandom_range(1, DIGITS);
		for (int i = 0; i < len; i++)
			scale = scale * 10;
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($urandom % scale);
			2: return $urandom_range(0, 99);
			default: begin
				if (scale > 64'hFFFF_FFFF)
					return 32'hFFFF_FFFF - $urandom_range(0, 3);
				return 32'(scale - $urandom_range(0, 2));
			end
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		frac_digits = '0;
		pad_two = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Zero with and without padding, and with fractional zeros.
		send_number(32'd0, 4'd0, 1'b0, 0);
		send_number(32'd0, 4'd0, 1'b1, 0);
		send_number(32'd0, 4'd9, 1'b0, 0);
		send_number(32'd0, 4'd15, 1'b1, 0);
		// Largest value at several point positions.
		send_number(32'hFFFF_FFFF, 4'd0, 1'b0, 0);
		send_number(32'hFFFF_FFFF, 4'd9, 1'b1, 0);
		send_number(32'hFFFF_FFFF, 4'd15, 1'b0, 0);
		// Short values padded out on either side of the point.
		send_number(32'd5, 4'd3, 1'b0, 0);
		send_number(32'd7, 4'd0, 1'b1, 0);
		send_number(32'd12345, 4'd2, 1'b1, 0);
		send_number(32'd123, 4'd5, 1'b0, 0);
		send_number(32'd9, 4'd1, 1'b1, 0);
		// The point at or near full width; at full width only one integer digit fits.
		send_number(32'd1, 4'd9, 1'b1, 0);
		send_number(32'd5, 4'd8, 1'b1, 0);
		send_number(32'd1_000_000_000, 4'd9, 1'b1, 0);
		// Fraction counts above the limit saturate; then alternating bit patterns and a round value.
		send_number(32'd10, 4'd10, 1'b0, 0);
		send_number(32'd999_999_999, 4'd12, 1'b0, 0);
		send_number(32'd42, 4'd14, 1'b1, 0);
		send_number(32'hAAAA_AAAA, 4'd4, 1'b0, 0);
		send_number(32'h5555_5555, 4'd6, 1'b1, 0);
		send_number(32'd100, 4'd2, 1'b0, 0);

		for (int n = 0; n < RANDOM_NUMBERS; n++)
			send_number(random_value(), 4'($urandom_range(0, 15)), 1'($urandom_range(1)),
				!(n >= 150 && n < 260));
		start <= 1'b0;

		while (board.owed() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dfmt_pkg.sv
rtl/dfmt_bcd_unit.sv
rtl/dfmt_seq.sv
rtl/decimal_ascii_formatter.sv
tb/sv/decimal_ascii_formatter_test.sv
